FILE: rtl/ppfa_pkg.sv
// ----------------------------------------------------------------------------
// ppfa_pkg
// Shared types and constants for the per-CPU page free-list allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ppfa_pkg;

   localparam int ADDR_W     = 32;
   localparam int PAGE_SHIFT = 12;
   localparam int PPN_W      = ADDR_W - PAGE_SHIFT;
   localparam int BASE_W     = PPN_W + 1;
   localparam int CPU_IN_W   = 3;
   localparam int STAT_W     = 2;

   localparam logic [ADDR_W-1:0] WINDOW_LOW_RST  = 32'h8000_0000;
   localparam logic [ADDR_W-1:0] WINDOW_HIGH_RST = 32'h8800_0000;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK  = 2'd0,
      STAT_OOM = 2'd1,
      STAT_BAD = 2'd2
   } status_type;

   typedef enum logic {
      CSR_WINDOW_LOW  = 1'b0,
      CSR_WINDOW_HIGH = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      BK_SWEEP = 2'd0,
      BK_IDLE  = 2'd1,
      BK_TABLE = 2'd2,
      BK_POP   = 2'd3
   } back_state_type;

endpackage

`default_nettype wire

FILE: rtl/percpu_page_freelist_allocator.sv
// ----------------------------------------------------------------------------
// percpu_page_freelist_allocator
// Per-CPU LIFO free lists of 4 KiB pages with donor stealing on allocate.
//
//   channel  ports                                   flow control
//   -------  --------------------------------------  ------------
//   req      req_cmd, req_cpu, req_free_addr         valid/stall
//   rsp      rsp_page_addr, rsp_status, rsp_stolen   valid/stall
//   csr      csr_index, csr_wdata                    valid/ready
//
// Requests pass an intake register and a two-entry queue to the list engine.
// The engine answers a bad free or out of memory from its idle state; a good
// free takes a table read then a table update, an allocate a table read, a
// link memory read and a table update. After reset the engine sweeps to
// build the initial chain on list zero; req_stall is high until it ends.
// A stalled response holds the engine; the queue keeps intake running.
// ----------------------------------------------------------------------------
`default_nettype none

module percpu_page_freelist_allocator
   import ppfa_pkg::*;
#(
   parameter int NUM_CPUS  = 8,
   parameter int NUM_PAGES = 32768
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_cmd,
   input  wire logic [CPU_IN_W-1:0] req_cpu,
   input  wire logic [ADDR_W-1:0]   req_free_addr,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [ADDR_W-1:0]        rsp_page_addr,
   output logic [STAT_W-1:0]        rsp_status,
   output logic                     rsp_stolen,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic                csr_index,
   input  wire logic [ADDR_W-1:0]   csr_wdata
);

   localparam int CPU_W   = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
   localparam int PG_W    = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
   localparam int ENTRY_W = 2 + CPU_W + PG_W;

   logic [ADDR_W-1:0]  window_low_ff, window_high_ff;
   logic [BASE_W-1:0]  base_ppn;
   logic               init_done;
   logic               q_push, q_ready, q_pop, q_valid;
   logic [ENTRY_W-1:0] q_wdata, q_rdata;

   assign csr_ready = 1'b1;

   // base rounded up to a page
   assign base_ppn = {1'b0, window_low_ff[ADDR_W-1:PAGE_SHIFT]}
                   + BASE_W'(|window_low_ff[PAGE_SHIFT-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         window_low_ff  <= WINDOW_LOW_RST;
         window_high_ff <= WINDOW_HIGH_RST;
      end else if (csr_valid && csr_ready) begin
         if (csr_index_type'(csr_index) == CSR_WINDOW_LOW) begin
            window_low_ff <= csr_wdata;
         end else begin
            window_high_ff <= csr_wdata;
         end
      end
   end

   ppfa_front #(
      .NUM_CPUS  (NUM_CPUS),
      .NUM_PAGES (NUM_PAGES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_cpu       (req_cpu),
      .req_free_addr (req_free_addr),
      .window_low    (window_low_ff),
      .window_high   (window_high_ff),
      .base_ppn      (base_ppn),
      .init_done     (init_done),
      .q_push        (q_push),
      .q_wdata       (q_wdata),
      .q_ready       (q_ready)
   );

   ppfa_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .ready (q_ready),
      .pop   (q_pop),
      .rdata (q_rdata),
      .valid (q_valid)
   );

   ppfa_back #(
      .NUM_CPUS  (NUM_CPUS),
      .NUM_PAGES (NUM_PAGES)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_rdata       (q_rdata),
      .q_pop         (q_pop),
      .base_ppn      (base_ppn),
      .init_done     (init_done),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_page_addr (rsp_page_addr),
      .rsp_status    (rsp_status),
      .rsp_stolen    (rsp_stolen)
   );

endmodule

`default_nettype wire

FILE: rtl/ppfa_queue.sv
// ----------------------------------------------------------------------------
// ppfa_queue
// Two-entry FIFO between the request classifier and the list engine.
// ----------------------------------------------------------------------------
`default_nettype none

module ppfa_queue
   import ppfa_pkg::*;
#(
   parameter int WIDTH = 20
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  ready,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rdata,
   output logic                  valid
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;

   assign ready = (fill_ff != 2'd2);
   assign valid = (fill_ff != 2'd0);
   assign rdata = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/ppfa_front.sv
// ----------------------------------------------------------------------------
// ppfa_front
// Request intake: registers one request, reduces the CPU index, checks a
// free address against the window and forms the page index.
// ----------------------------------------------------------------------------
`default_nettype none

module ppfa_front
   import ppfa_pkg::*;
#(
   parameter int NUM_CPUS  = 8,
   parameter int NUM_PAGES = 32768,
   localparam int CPU_W    = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1,
   localparam int PG_W     = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1,
   localparam int ENTRY_W  = 2 + CPU_W + PG_W
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_cmd,
   input  wire logic [CPU_IN_W-1:0] req_cpu,
   input  wire logic [ADDR_W-1:0]   req_free_addr,
   input  wire logic [ADDR_W-1:0]   window_low,
   input  wire logic [ADDR_W-1:0]   window_high,
   input  wire logic [BASE_W-1:0]   base_ppn,
   input  wire logic                init_done,
   output logic                     q_push,
   output logic [ENTRY_W-1:0]       q_wdata,
   input  wire logic                q_ready
);

   function automatic logic [CPU_W-1:0] cpu_wrap(input logic [CPU_IN_W-1:0] c);
      logic [6:0] r;
      r = 7'(c);
      for (int i = 0; i < 7; i++) begin
         if (r >= 7'(NUM_CPUS)) begin
            r = r - 7'(NUM_CPUS);
         end
      end
      return r[CPU_W-1:0];
   endfunction

   logic              s1_valid_ff, s1_valid_in;
   cmd_type           s1_cmd_ff;
   logic [CPU_W-1:0]  s1_cpu_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic              accept;
   logic              misalign, below, above, too_big, bad;
   logic [BASE_W-1:0] idx_full;

   assign req_stall = !init_done || (s1_valid_ff && !q_ready);
   assign accept    = req_valid && !req_stall;
   assign q_push    = s1_valid_ff && q_ready;

   always_comb begin
      misalign = |s1_addr_ff[PAGE_SHIFT-1:0];
      below    = s1_addr_ff < window_low;
      above    = s1_addr_ff >= window_high;
      idx_full = {1'b0, s1_addr_ff[ADDR_W-1:PAGE_SHIFT]} - base_ppn;
      too_big  = idx_full >= BASE_W'(NUM_PAGES);
      bad      = (s1_cmd_ff == CMD_FREE) && (misalign || below || above || too_big);
      q_wdata  = {s1_cmd_ff, bad, s1_cpu_ff, idx_full[PG_W-1:0]};
   end

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (q_push) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff  <= cmd_type'(req_cmd);
         s1_cpu_ff  <= cpu_wrap(req_cpu);
         s1_addr_ff <= req_free_addr;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/ppfa_back.sv
// ----------------------------------------------------------------------------
// ppfa_back
// List engine: per-CPU head and count tables, the page link memory, the
// donor search and the result register. Sweeps all tables after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ppfa_back
   import ppfa_pkg::*;
#(
   parameter int NUM_CPUS  = 8,
   parameter int NUM_PAGES = 32768,
   localparam int CPU_W    = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1,
   localparam int PG_W     = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1,
   localparam int ENTRY_W  = 2 + CPU_W + PG_W
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_valid,
   input  wire logic [ENTRY_W-1:0] q_rdata,
   output logic                    q_pop,
   input  wire logic [BASE_W-1:0]  base_ppn,
   output logic                    init_done,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [ADDR_W-1:0]       rsp_page_addr,
   output logic [STAT_W-1:0]       rsp_status,
   output logic                    rsp_stolen
);

   localparam int SWEEP = (NUM_PAGES > NUM_CPUS) ? NUM_PAGES : NUM_CPUS;
   localparam int SW_W  = (SWEEP > 1) ? $clog2(SWEEP) : 1;

   localparam longint RST_BASE =
      ((longint'(WINDOW_LOW_RST) + 64'd4095) >> PAGE_SHIFT) << PAGE_SHIFT;
   localparam longint RST_SPAN =
      (longint'(WINDOW_HIGH_RST) >= RST_BASE + 64'd4096) ?
      ((longint'(WINDOW_HIGH_RST) - RST_BASE) >> PAGE_SHIFT) : 64'd0;
   localparam longint INIT_PAGES =
      (RST_SPAN > longint'(NUM_PAGES)) ? longint'(NUM_PAGES) : RST_SPAN;

   localparam logic [SW_W:0]         PAGE_LIM  = (SW_W+1)'(NUM_PAGES);
   localparam logic [SW_W:0]         CPU_LIM   = (SW_W+1)'(NUM_CPUS);
   localparam logic [SW_W:0]         INIT_LIM  = (SW_W+1)'(INIT_PAGES);
   localparam logic [SW_W-1:0]       SW_LAST   = SW_W'(SWEEP - 1);
   localparam logic [PG_W-1:0]       INIT_HEAD = (INIT_PAGES > 0) ? PG_W'(INIT_PAGES - 1) : '0;
   localparam logic [31:0]           INIT_CNT  = 32'(INIT_PAGES);
   localparam logic [NUM_CPUS-1:0]   INIT_NZ   = NUM_CPUS'(INIT_PAGES > 0);

   // storage
   logic [PG_W-1:0] head_mem  [NUM_CPUS];
   logic [31:0]     count_mem [NUM_CPUS];
   logic [PG_W-1:0] link_mem  [NUM_PAGES];

   back_state_type  state_ff, state_in;
   logic [SW_W-1:0] sw_ptr_ff, sw_ptr_in;
   logic [NUM_CPUS-1:0] nz_ff, nz_in;
   logic [CPU_W-1:0] tgt_ff, tgt_in;
   cmd_type         cmd_ff, cmd_in;
   logic [PG_W-1:0] idx_ff, idx_in;
   logic            stolen_ff, stolen_in;
   logic [PG_W-1:0] head_rd_ff;
   logic [31:0]     count_rd_ff;
   logic [PG_W-1:0] link_rd_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_page_addr_ff, rsp_page_addr_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic              rsp_stolen_ff, rsp_stolen_in;

   logic             tbl_we, tbl_re;
   logic [CPU_W-1:0] tbl_waddr, tbl_raddr;
   logic [PG_W-1:0]  head_wdata;
   logic [31:0]      count_wdata;
   logic             link_we, link_re;
   logic [PG_W-1:0]  link_waddr, link_raddr, link_wdata;

   cmd_type          e_cmd;
   logic             e_bad;
   logic [CPU_W-1:0] e_cpu;
   logic [PG_W-1:0]  e_idx;
   logic             src_hit;
   logic [CPU_W-1:0] src_cpu;
   logic             out_free;
   logic [SW_W:0]    sw_ext;
   logic [SW_W-1:0]  sw_dec;

   assign e_cmd = cmd_type'(q_rdata[ENTRY_W-1]);
   assign e_bad = q_rdata[ENTRY_W-2];
   assign e_cpu = q_rdata[PG_W +: CPU_W];
   assign e_idx = q_rdata[PG_W-1:0];

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign init_done = (state_ff != BK_SWEEP);
   assign sw_ext    = {1'b0, sw_ptr_ff};
   assign sw_dec    = sw_ptr_ff - SW_W'(1);

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_page_addr = rsp_page_addr_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_stolen    = rsp_stolen_ff;

   // donor search: own list first, then cpu+1 upward with wrap
   always_comb begin
      logic [CPU_W:0] sum;
      logic [CPU_W:0] cand;
      src_hit = 1'b0;
      src_cpu = e_cpu;
      for (int k = NUM_CPUS - 1; k >= 1; k--) begin
         sum  = {1'b0, e_cpu} + (CPU_W+1)'(k);
         cand = (sum >= (CPU_W+1)'(NUM_CPUS)) ? sum - (CPU_W+1)'(NUM_CPUS) : sum;
         if (nz_ff[cand[CPU_W-1:0]]) begin
            src_hit = 1'b1;
            src_cpu = cand[CPU_W-1:0];
         end
      end
      if (nz_ff[e_cpu]) begin
         src_hit = 1'b1;
         src_cpu = e_cpu;
      end
   end

   always_comb begin
      state_in    = state_ff;
      sw_ptr_in   = sw_ptr_ff;
      nz_in       = nz_ff;
      tgt_in      = tgt_ff;
      cmd_in      = cmd_ff;
      idx_in      = idx_ff;
      stolen_in   = stolen_ff;
      q_pop       = 1'b0;
      tbl_we      = 1'b0;
      tbl_waddr   = tgt_ff;
      head_wdata  = '0;
      count_wdata = '0;
      tbl_re      = 1'b0;
      tbl_raddr   = tgt_ff;
      link_we     = 1'b0;
      link_waddr  = idx_ff;
      link_wdata  = head_rd_ff;
      link_re     = 1'b0;
      link_raddr  = head_rd_ff;

      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_page_addr_in = rsp_page_addr_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_stolen_in    = rsp_stolen_ff;

      unique case (state_ff)
         BK_SWEEP: begin
            link_we    = sw_ext < PAGE_LIM;
            link_waddr = sw_ptr_ff[PG_W-1:0];
            link_wdata = (sw_ext >= (SW_W+1)'(1) && sw_ext < INIT_LIM) ?
                         sw_dec[PG_W-1:0] : '0;
            tbl_we     = sw_ext < CPU_LIM;
            tbl_waddr  = sw_ptr_ff[CPU_W-1:0];
            head_wdata  = (sw_ptr_ff == '0) ? INIT_HEAD : '0;
            count_wdata = (sw_ptr_ff == '0) ? INIT_CNT : '0;
            if (sw_ptr_ff == SW_LAST) begin
               state_in = BK_IDLE;
            end else begin
               sw_ptr_in = sw_ptr_ff + SW_W'(1);
            end
         end
         BK_IDLE: begin
            if (q_valid && out_free) begin
               q_pop  = 1'b1;
               cmd_in = e_cmd;
               idx_in = e_idx;
               if (e_cmd == CMD_FREE) begin
                  if (e_bad) begin
                     rsp_valid_in     = 1'b1;
                     rsp_page_addr_in = '0;
                     rsp_status_in    = STAT_BAD;
                     rsp_stolen_in    = 1'b0;
                  end else begin
                     tgt_in    = e_cpu;
                     tbl_re    = 1'b1;
                     tbl_raddr = e_cpu;
                     state_in  = BK_TABLE;
                  end
               end else if (!src_hit) begin
                  rsp_valid_in     = 1'b1;
                  rsp_page_addr_in = '0;
                  rsp_status_in    = STAT_OOM;
                  rsp_stolen_in    = 1'b0;
               end else begin
                  tgt_in    = src_cpu;
                  stolen_in = (src_cpu != e_cpu);
                  tbl_re    = 1'b1;
                  tbl_raddr = src_cpu;
                  state_in  = BK_TABLE;
               end
            end
         end
         BK_TABLE: begin
            if (cmd_ff == CMD_FREE) begin
               link_we       = 1'b1;
               tbl_we        = 1'b1;
               head_wdata    = idx_ff;
               count_wdata   = count_rd_ff + 32'd1;
               nz_in[tgt_ff] = |count_wdata;
               rsp_valid_in     = 1'b1;
               rsp_page_addr_in = '0;
               rsp_status_in    = STAT_OK;
               rsp_stolen_in    = 1'b0;
               state_in      = BK_IDLE;
            end else begin
               link_re  = 1'b1;
               state_in = BK_POP;
            end
         end
         BK_POP: begin
            tbl_we        = 1'b1;
            head_wdata    = link_rd_ff;
            count_wdata   = count_rd_ff - 32'd1;
            nz_in[tgt_ff] = |count_wdata;
            rsp_valid_in     = 1'b1;
            rsp_page_addr_in = {base_ppn[PPN_W-1:0] + PPN_W'(head_rd_ff),
                                {PAGE_SHIFT{1'b0}}};
            rsp_status_in    = STAT_OK;
            rsp_stolen_in    = stolen_ff;
            state_in      = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_SWEEP;
         sw_ptr_ff    <= '0;
         nz_ff        <= INIT_NZ;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sw_ptr_ff    <= sw_ptr_in;
         nz_ff        <= nz_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tgt_ff           <= tgt_in;
      cmd_ff           <= cmd_in;
      idx_ff           <= idx_in;
      stolen_ff        <= stolen_in;
      rsp_page_addr_ff <= rsp_page_addr_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_stolen_ff    <= rsp_stolen_in;
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         head_mem[tbl_waddr]  <= head_wdata;
         count_mem[tbl_waddr] <= count_wdata;
      end
      if (tbl_re) begin
         head_rd_ff  <= head_mem[tbl_raddr];
         count_rd_ff <= count_mem[tbl_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      if (link_re) begin
         link_rd_ff <= link_mem[link_raddr];
      end
   end

endmodule

`default_nettype wire

FILE: bench/percpu_page_freelist_allocator_test.sv
// ----------------------------------------------------------------------------
// percpu_page_freelist_allocator_test
// Self-checking bench for the per-CPU page free-list allocator. A queue-fed
// driver issues allocate and free transfers in random bursts, and a scoreboard
// tracks the per-CPU lists, counts and page links to predict every response.
// The run covers directed corner cases, extreme window settings and random
// traffic under several windows.
// ----------------------------------------------------------------------------

module percpu_page_freelist_allocator_test;
   import ppfa_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CPUS        = 8;
   localparam int PAGES       = 32768;
   localparam int CYCLE_LIMIT = 4_000_000;

   typedef struct packed {
      cmd_type           cmd;
      logic [2:0]        cpu;
      logic [ADDR_W-1:0] addr;
   } page_req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] page_addr;
      status_type        status;
      logic              stolen;
   } page_rsp_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_cmd = 1'b0;
   logic [2:0]          req_cpu = '0;
   logic [ADDR_W-1:0]   req_free_addr = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [ADDR_W-1:0]   rsp_page_addr;
   logic [STAT_W-1:0]   rsp_status;
   logic                rsp_stolen;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic                csr_index = 1'b0;
   logic [ADDR_W-1:0]   csr_wdata = '0;

   percpu_page_freelist_allocator #(
      .NUM_CPUS (CPUS),
      .NUM_PAGES(PAGES)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_cmd      (req_cmd),
      .req_cpu      (req_cpu),
      .req_free_addr(req_free_addr),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_page_addr(rsp_page_addr),
      .rsp_status   (rsp_status),
      .rsp_stolen   (rsp_stolen),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // scoreboard copy of the allocator state
   logic [ADDR_W-1:0] win_low;
   logic [ADDR_W-1:0] win_high;
   logic [15:0]       head_page[CPUS];
   logic [31:0]       pages_on[CPUS];
   logic [15:0]       next_page[PAGES];

   page_req_type request_queue[$];
   page_rsp_type expected_grants[$];

   int mismatches = 0;
   int cycles = 0;
   int n_alloc = 0, n_steal = 0, n_oom = 0, n_free = 0, n_bad = 0, n_windows = 1;

   function automatic logic [32:0] page_base();
      return ({1'b0, win_low} + 33'h0_0000_0FFF) & ~33'h0_0000_0FFF;
   endfunction

   function automatic int unsigned window_pages();
      logic [32:0] base;
      logic [32:0] n;
      base = page_base();
      if ({1'b0, win_high} < base + 33'h1000)
         return 0;
      n = ({1'b0, win_high} - base) >> PAGE_SHIFT;
      if (n > PAGES)
         return PAGES;
      return int'(n);
   endfunction

   function automatic void reset_lists();
      int unsigned n;
      win_low  = WINDOW_LOW_RST;
      win_high = WINDOW_HIGH_RST;
      for (int c = 0; c < CPUS; c++) begin
         head_page[c] = '0;
         pages_on[c]  = '0;
      end
      for (int p = 0; p < PAGES; p++)
         next_page[p] = '0;
      n = window_pages();
      for (int unsigned i = 1; i < n; i++)
         next_page[i] = 16'(i - 1);
      if (n > 0) begin
         head_page[0] = 16'(n - 1);
         pages_on[0]  = n;
      end
   endfunction

   // applies one request to the scoreboard lists and returns the response
   function automatic page_rsp_type serve_request(page_req_type r);
      page_rsp_type o;
      logic [32:0]  base;
      logic [32:0]  idx;
      logic [32:0]  sum;
      logic [15:0]  pg;
      logic [2:0]   src;
      bit           found;
      bit           bad;
      o.page_addr = '0;
      o.status    = STAT_OK;
      o.stolen    = 1'b0;
      base = page_base();
      if (r.cmd == CMD_FREE) begin
         bad = (r.addr[PAGE_SHIFT-1:0] != '0) || (r.addr < win_low) || (r.addr >= win_high)
               || ({1'b0, r.addr} < base);
         if (!bad) begin
            idx = ({1'b0, r.addr} - base) >> PAGE_SHIFT;
            if (idx >= PAGES) begin
               bad = 1'b1;
            end else begin
               next_page[idx[15:0]] = head_page[r.cpu];
               head_page[r.cpu]     = idx[15:0];
               pages_on[r.cpu]      = pages_on[r.cpu] + 1;
            end
         end
         if (bad)
            o.status = STAT_BAD;
      end else begin
         src   = r.cpu;
         found = pages_on[r.cpu] != 0;
         for (int k = 1; k < CPUS; k++) begin
            if (!found && pages_on[3'(r.cpu + k)] != 0) begin
               src      = 3'(r.cpu + k);
               found    = 1'b1;
               o.stolen = 1'b1;
            end
         end
         if (found) begin
            pg             = head_page[src] % PAGES;
            head_page[src] = next_page[pg] % PAGES;
            pages_on[src]  = pages_on[src] - 1;
            sum            = base + (33'(pg) << PAGE_SHIFT);
            o.page_addr    = sum[31:0];
         end else begin
            o.status = STAT_OOM;
         end
      end
      return o;
   endfunction

   function automatic void queue_request(cmd_type c, logic [2:0] cpu, logic [ADDR_W-1:0] addr);
      page_req_type r;
      r.cmd  = c;
      r.cpu  = cpu;
      r.addr = addr;
      request_queue.push_back(r);
   endfunction

   function automatic void random_traffic(int count, int alloc_pct);
      logic [32:0] base;
      logic [32:0] a;
      int unsigned span;
      int unsigned pick;
      base = page_base();
      span = window_pages();
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < alloc_pct) begin
            queue_request(CMD_ALLOC, 3'($urandom_range(0, 7)), $urandom());
         end else begin
            if (pick < 88) begin
               a = base + (33'($urandom_range(0, span)) << PAGE_SHIFT);
            end else begin
               case ($urandom_range(0, 3))
                  0: a = {1'b0, $urandom()};
                  1: a = base + (33'($urandom_range(0, span)) << PAGE_SHIFT)
                         + 33'($urandom_range(1, 4095));
                  2: a = {1'b0, win_low} - 33'h1000;
                  default: a = {1'b0, win_high};
               endcase
            end
            queue_request(CMD_FREE, 3'($urandom_range(0, 7)), a[31:0]);
         end
      end
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      if (mismatches <= 40)
         $display("[%0t] %s: got %h, want %h", $time, what, got, want);
   endtask

   task automatic wait_idle();
      while (request_queue.size() != 0 || req_valid || expected_grants.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_window(csr_index_type idx, logic [ADDR_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_WINDOW_LOW)
         win_low = val;
      else
         win_high = val;
      n_windows++;
   endtask

   // driver: bursts of transfers separated by random gaps
   page_req_type in_flight;
   page_rsp_type predicted;
   int           burst_left = 16;
   int           gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predicted = serve_request(in_flight);
            expected_grants.push_back(predicted);
            if (in_flight.cmd == CMD_FREE) begin
               if (predicted.status == STAT_BAD)
                  n_bad++;
               else
                  n_free++;
            end else if (predicted.status == STAT_OOM) begin
               n_oom++;
            end else begin
               n_alloc++;
               if (predicted.stolen)
                  n_steal++;
            end
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (request_queue.size() != 0) begin
               in_flight = request_queue.pop_front();
               req_valid     <= 1'b1;
               req_cmd       <= in_flight.cmd;
               req_cpu       <= in_flight.cpu;
               req_free_addr <= in_flight.addr;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 48);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall pattern, in randomly drawn modes
   int stall_mode = 0;
   int stall_run = 0;

   always @(posedge clock) begin
      if (cycles % 256 == 0)
         stall_mode = $urandom_range(0, 3);
      if (stall_run > 0) begin
         stall_run--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: begin
               if ($urandom_range(0, 7) == 0)
                  stall_run = $urandom_range(1, 12);
               rsp_stall <= (stall_run > 0);
            end
            3: rsp_stall <= cycles[0];
            default: rsp_stall <= 1'b0;
         endcase
      end
   end

   // monitor
   page_rsp_type want;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_grants.size() == 0) begin
            report_mismatch("response with nothing outstanding", rsp_page_addr, 32'h0);
         end else begin
            want = expected_grants.pop_front();
            if (rsp_page_addr !== want.page_addr)
               report_mismatch("page_addr", rsp_page_addr, want.page_addr);
            if (rsp_status !== want.status)
               report_mismatch("status", 32'(rsp_status), 32'(want.status));
            if (rsp_stolen !== want.stolen)
               report_mismatch("stolen", 32'(rsp_stolen), 32'(want.stolen));
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycles, expected_grants.size());
         $display("percpu_page_freelist_allocator: mismatch");
         $finish;
      end
   end

   initial begin
      reset_lists();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // default window: own head, steal, push/pop, double free, rejected frees
      queue_request(CMD_ALLOC, 3'd0, 32'h0);
      queue_request(CMD_ALLOC, 3'd3, 32'hFFFF_FFFF);
      queue_request(CMD_FREE,  3'd5, 32'h87FF_F000);
      queue_request(CMD_FREE,  3'd7, 32'h87FF_E000);
      queue_request(CMD_ALLOC, 3'd5, 32'h1234_5678);
      queue_request(CMD_ALLOC, 3'd4, 32'h0);
      queue_request(CMD_FREE,  3'd1, 32'h87FF_F000);
      queue_request(CMD_FREE,  3'd1, 32'h87FF_F000);
      queue_request(CMD_ALLOC, 3'd1, 32'h0);
      queue_request(CMD_ALLOC, 3'd1, 32'h0);
      queue_request(CMD_FREE,  3'd2, 32'h87FF_F001);
      queue_request(CMD_FREE,  3'd2, 32'h7FFF_F000);
      queue_request(CMD_FREE,  3'd6, 32'h8800_0000);
      queue_request(CMD_FREE,  3'd7, 32'hFFFF_FFFF);
      queue_request(CMD_FREE,  3'd0, 32'h0000_0000);
      wait_idle();

      // whole address space: index past the page count is rejected
      write_window(CSR_WINDOW_LOW, 32'h0000_0000);
      write_window(CSR_WINDOW_HIGH, 32'hFFFF_FFFF);
      queue_request(CMD_FREE,  3'd6, 32'h0800_0000);
      queue_request(CMD_FREE,  3'd6, 32'h0000_0000);
      queue_request(CMD_ALLOC, 3'd6, 32'h0);
      queue_request(CMD_ALLOC, 3'd0, 32'h0);
      wait_idle();

      // base rounds up past 32 bits, then a base near the top that wraps
      write_window(CSR_WINDOW_LOW, 32'hFFFF_FFFF);
      queue_request(CMD_FREE,  3'd3, 32'hFFFF_F000);
      queue_request(CMD_ALLOC, 3'd2, 32'h0);
      wait_idle();
      write_window(CSR_WINDOW_LOW, 32'hFFFF_F000);
      queue_request(CMD_FREE,  3'd3, 32'hFFFF_F000);
      queue_request(CMD_ALLOC, 3'd3, 32'h0);
      queue_request(CMD_ALLOC, 3'd3, 32'h0);
      wait_idle();
      write_window(CSR_WINDOW_HIGH, 32'h0000_0000);
      queue_request(CMD_FREE,  3'd3, 32'hFFFF_F000);
      wait_idle();

      write_window(CSR_WINDOW_LOW, WINDOW_LOW_RST);
      write_window(CSR_WINDOW_HIGH, WINDOW_HIGH_RST);
      random_traffic(400, 50);
      wait_idle();

      // push on one list, then allocate from another
      queue_request(CMD_FREE,  3'd2, 32'h8000_0000);
      queue_request(CMD_ALLOC, 3'd6, 32'h0);
      queue_request(CMD_ALLOC, 3'd6, 32'h0);
      wait_idle();

      write_window(CSR_WINDOW_LOW, 32'h8000_0800);
      write_window(CSR_WINDOW_HIGH, 32'h8004_0000);
      random_traffic(400, 40);
      wait_idle();

      write_window(CSR_WINDOW_LOW, 32'h0000_0000);
      write_window(CSR_WINDOW_HIGH, 32'hFFFF_FFFF);
      random_traffic(400, 45);
      wait_idle();

      write_window(CSR_WINDOW_LOW, 32'hFFFF_0000);
      random_traffic(470, 50);
      wait_idle();
      repeat (16) @(posedge clock);

      $display("covered %0d allocations (%0d stolen), %0d out of memory, %0d frees, %0d rejected",
               n_alloc, n_steal, n_oom, n_free, n_bad);
      $display("window register writes: %0d, cycles: %0d", n_windows - 1, cycles);
      if (mismatches == 0)
         $display("percpu_page_freelist_allocator: match");
      else
         $display("percpu_page_freelist_allocator: mismatch");
      $finish;
   end

endmodule
